### sv/urd_pkg.sv
// Shared types and constants for the unsigned restoring divider.
// No dependencies; imported by the cell, the output buffer and the top level.
`timescale 1ns / 1ps

package urd_pkg;

  // Width of the operand and quotient ports.
  localparam int unsigned DataW = 64;

  // Control bits that travel with each request down the cell chain.
  typedef struct packed {
    logic valid;
    logic div_by_zero;
  } urd_ctrl_t;

  // One finished result as it leaves the chain.
  typedef struct packed {
    logic [DataW-1:0] quotient;
    logic             div_by_zero;
  } urd_result_t;

endpackage

### sv/urd_cell.sv
// One cell of the divider chain: a single restoring step, registered.
// Depends on urd_pkg for the control struct.
`timescale 1ns / 1ps

module urd_cell import urd_pkg::*; #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  urd_ctrl_t        ctrl_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [WIDTH-1:0] den_i,
  input  logic [WIDTH-1:0] quo_i,
  output urd_ctrl_t        ctrl_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] num_o,
  output logic [WIDTH-1:0] den_o,
  output logic [WIDTH-1:0] quo_o
);

  logic             carry;
  logic [WIDTH-1:0] shifted;
  logic             take;
  logic [WIDTH-1:0] rem_d, num_d, quo_d;
  urd_ctrl_t        ctrl_q;
  logic [WIDTH-1:0] rem_q, num_q, den_q, quo_q;

  // Shift the next dividend bit into the partial remainder; the bit that
  // falls off the top means the remainder already exceeds any divisor.
  always_comb begin
    carry   = rem_i[WIDTH-1];
    shifted = {rem_i[WIDTH-2:0], num_i[WIDTH-1]};
    take    = carry || (shifted >= den_i);
    rem_d   = take ? (shifted - den_i) : shifted;
    num_d   = {num_i[WIDTH-2:0], 1'b0};
    quo_d   = {quo_i[WIDTH-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign quo_o  = quo_q;

endmodule

### sv/urd_out_buf.sv
// Output register with a skid entry behind the divider chain.
// Depends on urd_pkg for the result struct.
`timescale 1ns / 1ps

module urd_out_buf import urd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  urd_result_t in_data_i,
  output logic        full_o,
  output logic        out_valid_o,
  output urd_result_t out_data_o,
  input  logic        out_ready_i
);

  logic        out_valid_q, skid_valid_q;
  urd_result_t out_data_q, skid_data_q;
  logic        push;
  logic        out_free;

  // The chain only moves while the skid entry is empty.
  assign push     = in_valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (push) begin
      skid_data_q <= in_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/unsigned_restoring_divider.sv
// Top level of the pipelined unsigned restoring divider.
// Depends on urd_pkg, urd_cell and urd_out_buf.
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ---------------------------------
//   request   in_valid_i / in_ready_o      dividend_i[63:0], divisor_i[63:0]
//   result    out_valid_o / out_ready_i    quotient_o[63:0], div_by_zero_o
//
// A new request is taken every cycle while the skid entry is empty. Each
// request walks a chain of WIDTH cells, one quotient bit per cell, and lands
// in the output register. The whole chain moves together; it halts only
// while the skid entry behind the output register is occupied, which
// happens when the output is held as a new result arrives. Reset clears the
// valid bits of every cell and of the output buffer; no clearing pass is
// needed.
`timescale 1ns / 1ps

module unsigned_restoring_divider import urd_pkg::*; #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] quotient_o,
  output logic             div_by_zero_o
);

  // Signals between neighboring cells; index 0 is the chain input and
  // index WIDTH the output of the last cell.
  urd_ctrl_t        ctrl_s [WIDTH+1];
  logic [WIDTH-1:0] rem_s  [WIDTH+1];
  logic [WIDTH-1:0] num_s  [WIDTH+1];
  logic [WIDTH-1:0] den_s  [WIDTH+1];
  logic [WIDTH-1:0] quo_s  [WIDTH+1];

  logic        advance;
  logic        buf_full;
  urd_result_t result;
  urd_result_t out_data;

  // Every cell advances in the same cycle, so the chain acts as one shift
  // line; the skid entry absorbs the one result that is in flight when the
  // consumer stops taking them.
  assign advance    = !buf_full;
  assign in_ready_o = advance;

  // Only the low WIDTH bits of each operand take part in the division.
  always_comb begin
    ctrl_s[0].valid       = in_valid_i;
    ctrl_s[0].div_by_zero = (divisor_i[WIDTH-1:0] == '0);
    rem_s[0]              = '0;
    num_s[0]              = dividend_i[WIDTH-1:0];
    den_s[0]              = divisor_i[WIDTH-1:0];
    quo_s[0]              = '0;
  end

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    urd_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .ctrl_i (ctrl_s[i]),
      .rem_i  (rem_s[i]),
      .num_i  (num_s[i]),
      .den_i  (den_s[i]),
      .quo_i  (quo_s[i]),
      .ctrl_o (ctrl_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .num_o  (num_s[i+1]),
      .den_o  (den_s[i+1]),
      .quo_o  (quo_s[i+1])
    );
  end

  // A zero divisor runs through the chain like any other request; its
  // quotient is forced to zero here and the flag is raised instead.
  always_comb begin
    result             = '0;
    result.div_by_zero = ctrl_s[WIDTH].div_by_zero;
    if (!ctrl_s[WIDTH].div_by_zero) begin
      result.quotient[WIDTH-1:0] = quo_s[WIDTH];
    end
  end

  urd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ctrl_s[WIDTH].valid),
    .in_data_i   (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .out_ready_i (out_ready_i)
  );

  assign quotient_o    = out_data.quotient;
  assign div_by_zero_o = out_data.div_by_zero;

endmodule
